>>> hdl/csp_pkg.sv
// Shared types, codes and constants of the column specification parser.
`timescale 1ns / 1ps

package csp_pkg;

  // Number and field widths
  localparam int NUM_W  = 31;
  localparam int CHAR_W = 8;

  // Largest number a specification may carry
  localparam logic [NUM_W-1:0] NUM_MAX = 31'h7FFF_FFFF;

  // Element defaults
  localparam logic [NUM_W-1:0] DEF_PRECISION = 31'd16;
  localparam logic [NUM_W-1:0] DEF_SCALE     = 31'd6;

  // Characters of the grammar
  localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;
  localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // Default depth of the result queue
  localparam int RESULT_DEPTH = 4;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_ELEM  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  // Parse error codes
  typedef enum logic [2:0] {
    ERR_END       = 3'd0,
    ERR_NO_NUMBER = 3'd1,
    ERR_NO_TYPE   = 3'd2,
    ERR_BRACKET   = 3'd3,
    ERR_TOO_LARGE = 3'd4
  } err_t;

  // One result item
  typedef struct packed {
    logic [1:0]        kind;
    logic [CHAR_W-1:0] type_char;
    logic [NUM_W-1:0]  size_len;
    logic [NUM_W-1:0]  precision;
    logic [NUM_W-1:0]  scale;
    logic [2:0]        error_code;
    logic              last_result;
  } result_t;

  // Results produced by one character: up to two, in order
  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } push_t;

endpackage

>>> hdl/csp_if.sv
// Handshake interfaces for the character and result channels.
`timescale 1ns / 1ps

interface csp_spec_if;
  import csp_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] ch;
  logic              last_char;

  modport source (output valid, output ch, output last_char, input ready);
  modport sink   (input valid, input ch, input last_char, output ready);
endinterface

interface csp_result_if;
  import csp_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [CHAR_W-1:0] type_char;
  logic [NUM_W-1:0]  size_len;
  logic [NUM_W-1:0]  precision;
  logic [NUM_W-1:0]  scale;
  logic [2:0]        error_code;
  logic              last_result;

  modport source (output valid, output kind, output type_char, output size_len,
                  output precision, output scale, output error_code,
                  output last_result, input ready);
  modport sink   (input valid, input kind, input type_char, input size_len,
                  input precision, input scale, input error_code,
                  input last_result, output ready);
endinterface

>>> hdl/csp_parse.sv
// Parse state and per-character grammar logic.
`timescale 1ns / 1ps

module csp_parse import csp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [CHAR_W-1:0] ch,
  input  logic              last_char,
  output push_t             push
);

  typedef enum logic [8:0] {
    PH_START   = 9'b000000001,
    PH_NAME    = 9'b000000010,
    PH_N1_WAIT = 9'b000000100,
    PH_N1      = 9'b000001000,
    PH_AFTER1  = 9'b000010000,
    PH_N2_WAIT = 9'b000100000,
    PH_N2      = 9'b001000000,
    PH_AFTER2  = 9'b010000000,
    PH_TAIL    = 9'b100000000
  } phase_t;

  phase_t           phase, phase_next;
  logic [NUM_W-1:0] first_number, first_number_next;
  logic [NUM_W-1:0] second_number, second_number_next;
  logic             two_seen, two_seen_next;
  logic             one_seen, one_seen_next;
  logic             lead_space, lead_space_next;
  logic             halted, halted_next;

  logic [CHAR_W-1:0] c;
  logic              is_digit, is_alpha, is_space;
  logic [NUM_W-1:0]  acc;
  logic [NUM_W+3:0]  acc_sum;
  logic              acc_ovf;
  result_t           r0, r1;
  logic              v0, v1;

  function automatic result_t elem_rec(input logic [NUM_W-1:0] n1,
                                       input logic [NUM_W-1:0] n2,
                                       input logic one, input logic two);
    result_t r;
    r = '0;
    r.kind = KIND_ELEM;
    if (two) begin
      r.precision = (n1 < n2) ? n2 : n1;
      r.scale     = n2;
    end else begin
      r.size_len  = one ? n1 : '0;
      r.precision = DEF_PRECISION;
      r.scale     = DEF_SCALE;
    end
    return r;
  endfunction

  function automatic result_t err_rec(input err_t code);
    result_t r;
    r = '0;
    r.kind       = KIND_ERROR;
    r.error_code = code;
    return r;
  endfunction

  function automatic result_t char_rec(input logic [CHAR_W-1:0] cc);
    result_t r;
    r = '0;
    r.kind      = KIND_CHAR;
    r.type_char = cc;
    return r;
  endfunction

  // Fold to lower case and classify
  always_comb begin
    c = ch;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      c = ch + 8'd32;
    end
    is_digit = (c >= 8'h30) && (c <= 8'h39);
    is_alpha = (c >= 8'h61) && (c <= 8'h7A);
    is_space = (c == CH_SPACE);
  end

  // Accumulate one decimal digit: acc * 10 + digit, shared by both numbers
  always_comb begin
    acc = ((phase == PH_N2_WAIT) || (phase == PH_N2)) ? second_number : first_number;
    acc_sum = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{(NUM_W){1'b0}}, c[3:0]};
    acc_ovf = acc_sum > {4'b0, NUM_MAX};
  end

  // Step the grammar on one character, then close the string on its last one
  always_comb begin
    phase_next         = phase;
    first_number_next  = first_number;
    second_number_next = second_number;
    two_seen_next      = two_seen;
    one_seen_next      = one_seen;
    lead_space_next    = lead_space;
    halted_next        = halted;
    v0 = 1'b0;
    v1 = 1'b0;
    r0 = '0;
    r1 = '0;

    if (halted) begin
      if (last_char) begin
        phase_next         = PH_START;
        first_number_next  = '0;
        second_number_next = '0;
        two_seen_next      = 1'b0;
        one_seen_next      = 1'b0;
        lead_space_next    = 1'b0;
        halted_next        = 1'b0;
      end
    end else begin
      case (phase)
        PH_START: begin
          if (is_space) begin
            lead_space_next = 1'b1;
          end else if (is_alpha || is_digit) begin
            v0 = 1'b1;
            r0 = char_rec(c);
            phase_next = PH_NAME;
          end else begin
            v0 = 1'b1;
            r0 = err_rec(ERR_NO_TYPE);
            halted_next = 1'b1;
          end
        end
        PH_NAME, PH_TAIL: begin
          if ((phase == PH_NAME) && (is_alpha || is_digit)) begin
            v0 = 1'b1;
            r0 = char_rec(c);
          end else if ((phase == PH_NAME) && (c == CH_OPEN)) begin
            phase_next = PH_N1_WAIT;
          end else if (is_space) begin
            phase_next = PH_TAIL;
          end else begin
            // Delimiter: give the record and start a new element
            v0 = 1'b1;
            r0 = elem_rec(first_number, second_number, one_seen, two_seen);
            phase_next         = PH_START;
            first_number_next  = '0;
            second_number_next = '0;
            two_seen_next      = 1'b0;
            one_seen_next      = 1'b0;
            lead_space_next    = 1'b0;
          end
        end
        PH_N1_WAIT, PH_N1: begin
          if (is_digit) begin
            one_seen_next = 1'b1;
            if (acc_ovf) begin
              v0 = 1'b1;
              r0 = err_rec(ERR_TOO_LARGE);
              halted_next = 1'b1;
            end else begin
              first_number_next = acc_sum[NUM_W-1:0];
              phase_next = PH_N1;
            end
          end else if (phase == PH_N1_WAIT) begin
            v0 = 1'b1;
            r0 = err_rec(ERR_NO_NUMBER);
            halted_next = 1'b1;
          end else if (is_space) begin
            phase_next = PH_AFTER1;
          end else if (c == CH_COMMA) begin
            phase_next = PH_N2_WAIT;
          end else if (c == CH_CLOSE) begin
            phase_next = PH_TAIL;
          end else begin
            v0 = 1'b1;
            r0 = err_rec(ERR_BRACKET);
            halted_next = 1'b1;
          end
        end
        PH_AFTER1: begin
          if (c == CH_COMMA) begin
            phase_next = PH_N2_WAIT;
          end else if (c == CH_CLOSE) begin
            phase_next = PH_TAIL;
          end else if (!is_space) begin
            v0 = 1'b1;
            r0 = err_rec(ERR_BRACKET);
            halted_next = 1'b1;
          end
        end
        PH_N2_WAIT, PH_N2: begin
          if (is_digit) begin
            two_seen_next = 1'b1;
            if (acc_ovf) begin
              v0 = 1'b1;
              r0 = err_rec(ERR_TOO_LARGE);
              halted_next = 1'b1;
            end else begin
              second_number_next = acc_sum[NUM_W-1:0];
              phase_next = PH_N2;
            end
          end else if (phase == PH_N2_WAIT) begin
            if (!is_space) begin
              v0 = 1'b1;
              r0 = err_rec(ERR_NO_NUMBER);
              halted_next = 1'b1;
            end
          end else if (is_space) begin
            phase_next = PH_AFTER2;
          end else if (c == CH_CLOSE) begin
            phase_next = PH_TAIL;
          end else begin
            v0 = 1'b1;
            r0 = err_rec(ERR_BRACKET);
            halted_next = 1'b1;
          end
        end
        PH_AFTER2: begin
          if (c == CH_CLOSE) begin
            phase_next = PH_TAIL;
          end else if (!is_space) begin
            v0 = 1'b1;
            r0 = err_rec(ERR_BRACKET);
            halted_next = 1'b1;
          end
        end
        default: begin
          v0 = 1'b1;
          r0 = err_rec(ERR_END);
          halted_next = 1'b1;
        end
      endcase

      // Close the string: give what is pending, then return to element start
      if (last_char) begin
        if (!halted_next) begin
          case (phase_next)
            PH_START: begin
              if (lead_space_next) begin
                v1 = 1'b1;
                r1 = err_rec(ERR_END);
              end
            end
            PH_NAME, PH_TAIL: begin
              v1 = 1'b1;
              r1 = elem_rec(first_number_next, second_number_next,
                            one_seen_next, two_seen_next);
            end
            PH_N1_WAIT, PH_N2_WAIT: begin
              v1 = 1'b1;
              r1 = err_rec(ERR_END);
            end
            default: begin
              v1 = 1'b1;
              r1 = err_rec(ERR_BRACKET);
            end
          endcase
        end
        phase_next         = PH_START;
        first_number_next  = '0;
        second_number_next = '0;
        two_seen_next      = 1'b0;
        one_seen_next      = 1'b0;
        lead_space_next    = 1'b0;
        halted_next        = 1'b0;
      end
    end

    r0.last_result = !v1;
    r1.last_result = 1'b1;
  end

  // Hand the results of an accepted character to the queue
  always_comb begin
    push.v0 = fire && v0;
    push.v1 = fire && v1;
    push.r0 = r0;
    push.r1 = r1;
  end

  // Advance parse state on each processed character
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_START;
      first_number  <= '0;
      second_number <= '0;
      two_seen      <= 1'b0;
      one_seen      <= 1'b0;
      lead_space    <= 1'b0;
      halted        <= 1'b0;
    end else if (fire) begin
      phase         <= phase_next;
      first_number  <= first_number_next;
      second_number <= second_number_next;
      two_seen      <= two_seen_next;
      one_seen      <= one_seen_next;
      lead_space    <= lead_space_next;
      halted        <= halted_next;
    end
  end

endmodule

>>> hdl/csp_rfifo.sv
// Result queue: takes up to two results a cycle, gives one a cycle while the consumer is ready.
`timescale 1ns / 1ps

module csp_rfifo import csp_pkg::*; #(
  parameter int DEPTH = RESULT_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  push_t               push,
  output logic                room,
  csp_result_if.source        result
);

  localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  result_t          mem [DEPTH];
  logic [PTR_W-1:0] wp, rp, wp1;
  logic [CNT_W-1:0] count;
  logic [1:0]       n_push;
  logic             pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == LAST_PTR) ? '0 : p + 1'b1;
  endfunction

  assign wp1    = ptr_inc(wp);
  assign n_push = {1'b0, push.v0} + {1'b0, push.v1};
  assign pop    = result.valid && result.ready;
  assign room   = count <= CNT_W'(DEPTH - 2);

  // Store pushed results in order
  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem[wp] <= push.r0;
    end
    if (push.v1) begin
      mem[push.v0 ? wp1 : wp] <= push.r1;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      case (n_push)
        2'd1:    wp <= wp1;
        2'd2:    wp <= ptr_inc(wp1);
        default: wp <= wp;
      endcase
      if (pop) begin
        rp <= ptr_inc(rp);
      end
      count <= count + CNT_W'(n_push) - CNT_W'(pop);
    end
  end

  // Present the head of the queue
  assign result.valid       = count != '0;
  assign result.kind        = mem[rp].kind;
  assign result.type_char   = mem[rp].type_char;
  assign result.size_len    = mem[rp].size_len;
  assign result.precision   = mem[rp].precision;
  assign result.scale       = mem[rp].scale;
  assign result.error_code  = mem[rp].error_code;
  assign result.last_result = mem[rp].last_result;

endmodule

>>> hdl/column_spec_parser.sv
// Top level of the column specification parser.
//
//   channel  | dir | payload                                          | transaction
//   spec     | in  | ch, last_char                                    | one character
//   result   | out | kind, type_char, size_len, precision, scale,     | one result
//            |     | error_code, last_result                          |
//
// A character is taken into an input register, then parsed from that register;
// one character per cycle is sustained while the consumer keeps up.
// Each character yields zero, one or two results into a DEPTH-entry queue;
// a character is parsed only while the queue has two free entries.
// Reset (rst, synchronous) returns the parser to element start and empties the queue.
// A stalled consumer backs up through the queue to spec.ready without loss.
`timescale 1ns / 1ps

module column_spec_parser import csp_pkg::*; #(
  parameter int DEPTH = RESULT_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  csp_spec_if.sink     spec,
  csp_result_if.source result
);

  logic              s_valid;
  logic [CHAR_W-1:0] s_ch;
  logic              s_last;
  logic              room;
  logic              fire;
  push_t             push;

  assign fire       = s_valid && room;
  assign spec.ready = !s_valid || fire;

  // Hold the accepted character until the parser takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (spec.valid && spec.ready) begin
      s_valid <= 1'b1;
    end else if (fire) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (spec.valid && spec.ready) begin
      s_ch   <= spec.ch;
      s_last <= spec.last_char;
    end
  end

  csp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .ch        (s_ch),
    .last_char (s_last),
    .push      (push)
  );

  csp_rfifo #(
    .DEPTH (DEPTH)
  ) u_rfifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .room   (room),
    .result (result)
  );

endmodule

>>> sim/tb.sv
// Self-checking testbench for the column specification parser.
`timescale 1ns / 1ps

module tb;
  import csp_pkg::*;

  localparam int RAND_ITEMS  = 1200;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_LEN    = 300;

  // Parser phases tracked by the predictor
  typedef enum logic [3:0] {
    P_START, P_NAME, P_OPEN, P_NUM1, P_GAP1, P_COMMA, P_NUM2, P_GAP2, P_TAIL
  } phase_t;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              is_last;
    logic              hold_back;
  } spec_item_t;

  logic clk;
  logic rst = 1'b1;

  csp_spec_if   spec_ch ();
  csp_result_if result_ch ();

  column_spec_parser DUT (
    .clk    (clk),
    .rst    (rst),
    .spec   (spec_ch),
    .result (result_ch)
  );

  // Drive the block inputs from known values at time zero
  logic              drv_valid = 1'b0;
  logic [CHAR_W-1:0] drv_ch    = '0;
  logic              drv_last  = 1'b0;
  logic              rcv_ready = 1'b0;

  assign spec_ch.valid     = drv_valid;
  assign spec_ch.ch        = drv_ch;
  assign spec_ch.last_char = drv_last;
  assign result_ch.ready   = rcv_ready;

  spec_item_t        pending[$];
  result_t           want_q[$];
  result_t           step_q[$];
  logic [CHAR_W-1:0] spell[$];

  int      taken_cnt = 0;
  int      bad_cnt   = 0;
  int      cycle_cnt = 0;
  int      hold_left = 0;
  bit      hold_done = 0;
  int      snd_gap   = 0;
  int      rcv_gap   = 0;
  bit      snd_calm  = 0;
  bit      rcv_calm  = 0;

  // Predictor state
  phase_t           phase    = P_START;
  logic [NUM_W-1:0] num_a    = '0;
  logic [NUM_W-1:0] num_b    = '0;
  logic             two_seen = 1'b0;
  logic             one_seen = 1'b0;
  logic             lead_sp  = 1'b0;
  logic             halted   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic result_t mk_result(kind_t k, logic [CHAR_W-1:0] tc,
                                        logic [NUM_W-1:0] len, prec, sc, err_t e);
    result_t r;
    r.kind        = k;
    r.type_char   = tc;
    r.size_len    = len;
    r.precision   = prec;
    r.scale       = sc;
    r.error_code  = e;
    r.last_result = 1'b0;
    return r;
  endfunction

  function automatic string show(result_t r);
    return $sformatf("kind=%0d char=%02h len=%0d prec=%0d scale=%0d err=%0d last=%0d",
                     r.kind, r.type_char, r.size_len, r.precision, r.scale,
                     r.error_code, r.last_result);
  endfunction

  // Build the element record; the code field stays zero outside errors
  function automatic result_t elem_record();
    if (two_seen)
      return mk_result(KIND_ELEM, '0, '0, (num_a < num_b) ? num_b : num_a, num_b, ERR_END);
    else if (one_seen)
      return mk_result(KIND_ELEM, '0, num_a, DEF_PRECISION, DEF_SCALE, ERR_END);
    else
      return mk_result(KIND_ELEM, '0, '0, DEF_PRECISION, DEF_SCALE, ERR_END);
  endfunction

  function automatic logic [63:0] grow(logic [NUM_W-1:0] acc, logic [CHAR_W-1:0] c);
    return 64'(acc) * 64'd10 + 64'(c - "0");
  endfunction

  task automatic clear_element();
    phase    = P_START;
    num_a    = '0;
    num_b    = '0;
    two_seen = 1'b0;
    one_seen = 1'b0;
    lead_sp  = 1'b0;
  endtask

  task automatic raise(err_t e);
    step_q = {step_q, mk_result(KIND_ERROR, '0, '0, '0, '0, e)};
    halted = 1'b1;
  endtask

  task automatic emit_elem();
    step_q = {step_q, elem_record()};
  endtask

  // Predict the results of one accepted character
  task automatic parse_char(logic [CHAR_W-1:0] c_raw, logic is_last);
    logic [CHAR_W-1:0] c;
    logic [63:0]       grown;
    logic              is_dig, is_alpha, is_sp;
    result_t           r;
    if (halted) begin
      if (is_last) begin
        clear_element();
        halted = 1'b0;
      end
      return;
    end
    c = c_raw;
    if (c >= "A" && c <= "Z")
      c = c + 8'd32;
    is_dig   = c >= "0" && c <= "9";
    is_alpha = c >= "a" && c <= "z";
    is_sp    = c == CH_SPACE;

    case (phase)
      P_START: begin
        if (is_sp) begin
          lead_sp = 1'b1;
        end else if (is_alpha || is_dig) begin
          step_q = {step_q, mk_result(KIND_CHAR, c, '0, '0, '0, ERR_END)};
          phase = P_NAME;
        end else begin
          raise(ERR_NO_TYPE);
        end
      end
      P_NAME: begin
        if (is_alpha || is_dig) begin
          step_q = {step_q, mk_result(KIND_CHAR, c, '0, '0, '0, ERR_END)};
        end else if (c == CH_OPEN) begin
          phase = P_OPEN;
        end else if (is_sp) begin
          phase = P_TAIL;
        end else begin
          emit_elem();
          clear_element();
        end
      end
      P_TAIL: begin
        if (!is_sp) begin
          emit_elem();
          clear_element();
        end
      end
      P_OPEN, P_NUM1: begin
        if (is_dig) begin
          one_seen = 1'b1;
          grown = grow(num_a, c);
          if (grown > NUM_MAX) begin
            raise(ERR_TOO_LARGE);
          end else begin
            num_a = grown[NUM_W-1:0];
            phase = P_NUM1;
          end
        end else if (phase == P_OPEN) begin
          raise(ERR_NO_NUMBER);
        end else if (is_sp) begin
          phase = P_GAP1;
        end else if (c == CH_COMMA) begin
          phase = P_COMMA;
        end else if (c == CH_CLOSE) begin
          phase = P_TAIL;
        end else begin
          raise(ERR_BRACKET);
        end
      end
      P_GAP1: begin
        if (c == CH_COMMA) phase = P_COMMA;
        else if (c == CH_CLOSE) phase = P_TAIL;
        else if (!is_sp) raise(ERR_BRACKET);
      end
      P_COMMA, P_NUM2: begin
        if (is_dig) begin
          two_seen = 1'b1;
          grown = grow(num_b, c);
          if (grown > NUM_MAX) begin
            raise(ERR_TOO_LARGE);
          end else begin
            num_b = grown[NUM_W-1:0];
            phase = P_NUM2;
          end
        end else if (phase == P_COMMA) begin
          if (!is_sp) raise(ERR_NO_NUMBER);
        end else if (is_sp) begin
          phase = P_GAP2;
        end else if (c == CH_CLOSE) begin
          phase = P_TAIL;
        end else begin
          raise(ERR_BRACKET);
        end
      end
      P_GAP2: begin
        if (c == CH_CLOSE) phase = P_TAIL;
        else if (!is_sp) raise(ERR_BRACKET);
      end
      default: raise(ERR_END);
    endcase

    // Close the string at its final character
    if (is_last) begin
      if (!halted) begin
        case (phase)
          P_START:          if (lead_sp) raise(ERR_END);
          P_NAME, P_TAIL:   emit_elem();
          P_OPEN, P_COMMA:  raise(ERR_END);
          default:          raise(ERR_BRACKET);
        endcase
      end
      clear_element();
      halted = 1'b0;
    end

    // Mark the final result of this character and queue them all
    if (step_q.size() != 0) begin
      r = step_q.pop_back();
      r.last_result = 1'b1;
      step_q = {step_q, r};
    end
    while (step_q.size() != 0)
      want_q = {want_q, step_q.pop_front()};
  endtask

  // String building
  task automatic add_char(logic [CHAR_W-1:0] b);
    spell = {spell, b};
  endtask

  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++)
      add_char(s[i]);
  endtask

  task automatic put_spaces(int most);
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, most)) add_char(CH_SPACE);
  endtask

  task automatic put_num();
    longint v;
    case ($urandom_range(0, 19))
      0:       v = $urandom_range(2147483647, 2147483600);
      1:       v = 64'd2147483648 + $urandom_range(0, 1000);
      2:       v = 64'd2147483648 + longint'($urandom) * 3;
      3:       v = 0;
      4, 5:    v = $urandom & 32'h7FFF_FFFF;
      6, 7, 8: v = $urandom_range(0, 99999);
      default: v = $urandom_range(0, 99);
    endcase
    if ($urandom_range(0, 9) == 0)
      add_char("0");
    put_str($sformatf("%0d", v));
  endtask

  function automatic logic [CHAR_W-1:0] pick_delim(bit after_name);
    logic [CHAR_W-1:0] d;
    logic              alnum;
    do begin
      case ($urandom_range(0, 3))
        0:       d = CH_COMMA;
        1:       d = ";";
        2:       d = "|";
        default: d = CHAR_W'($urandom_range(0, 255));
      endcase
      alnum = (d >= "0" && d <= "9") || (d >= "a" && d <= "z") || (d >= "A" && d <= "Z");
    end while (d == CH_SPACE || (after_name && (alnum || d == CH_OPEN)));
    return d;
  endfunction

  // Move the built string to the pending items, final character marked
  task automatic ship(bit hold);
    spec_item_t it;
    for (int i = 0; i < spell.size(); i++) begin
      it.ch        = spell[i];
      it.is_last   = (i == spell.size() - 1);
      it.hold_back = hold && (i == 0);
      pending = {pending, it};
    end
    spell.delete();
  endtask

  // Stimulus, reset and end of run
  initial begin
    int  n_directed, n_elem, form, roll, cut;
    bit  hold, trail;

    // Directed strings: byte extremes, every error, the two-number and the bare element forms
    add_char(8'hFF);        ship(0);
    add_char(8'h00);        ship(0);
    put_str(" ");           ship(0);
    put_str("A(");          ship(0);
    put_str("b( 1)");       ship(0);
    put_str("c(1x");        ship(0);
    put_str("d(1");         ship(0);
    put_str("e(3,12);Q");   ship(0);
    put_str("h(2147483648"); ship(0);
    n_directed = pending.size();

    // Random strings: mostly well formed, some broken, some noise
    hold = 1;
    while (pending.size() < n_directed + RAND_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        repeat ($urandom_range(1, 8)) begin
          case ($urandom_range(0, 7))
            0:       add_char(CH_SPACE);
            1:       add_char(CH_OPEN);
            2:       add_char(CH_CLOSE);
            3:       add_char(CH_COMMA);
            4:       add_char("z");
            default: add_char(CHAR_W'($urandom_range(0, 255)));
          endcase
        end
      end else begin
        n_elem = $urandom_range(1, 4);
        for (int e = 0; e < n_elem; e++) begin
          put_spaces(2);
          repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 2))
              0:       add_char(CHAR_W'("a" + $urandom_range(0, 25)));
              1:       add_char(CHAR_W'("A" + $urandom_range(0, 25)));
              default: add_char(CHAR_W'("0" + $urandom_range(0, 9)));
            endcase
          end
          form = $urandom_range(0, 2);
          if (form != 0) begin
            add_char(CH_OPEN);
            put_num();
            put_spaces(2);
            if (form == 2) begin
              add_char(CH_COMMA);
              put_spaces(2);
              put_num();
              put_spaces(2);
            end
            add_char(CH_CLOSE);
          end
          trail = $urandom_range(0, 3) == 0;
          if (trail)
            add_char(CH_SPACE);
          if (e < n_elem - 1 || $urandom_range(0, 9) == 0)
            add_char(pick_delim(form == 0 && !trail));
        end
        // Break some strings by a replaced byte or a cut
        if (roll < 24) begin
          if ($urandom_range(0, 1) == 0) begin
            spell[$urandom_range(0, spell.size() - 1)] = CHAR_W'($urandom_range(0, 255));
          end else begin
            cut = $urandom_range(1, spell.size());
            while (spell.size() > cut) spell.pop_back();
          end
        end
      end
      ship(hold);
      hold = $urandom_range(0, 29) == 0;
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk); while (pending.size() != 0 || drv_valid || want_q.size() != 0);
    repeat (40) @(posedge clk);
    if (bad_cnt == 0 && want_q.size() == 0)
      $display("PASS column_spec_parser");
    else
      $display("FAIL column_spec_parser");
    $finish;
  end

  // Character driver: random gap before each character, wait for drain on request
  always @(posedge clk) begin
    spec_item_t nxt;
    bit         busy;
    if (rst) begin
      drv_valid <= 1'b0;
      drv_ch    <= '0;
      drv_last  <= 1'b0;
      snd_gap   = 0;
    end else begin
      busy = drv_valid;
      if (drv_valid && spec_ch.ready) begin
        parse_char(drv_ch, drv_last);
        taken_cnt <= taken_cnt + 1;
        busy = 0;
        snd_gap = snd_calm ? 0 : $urandom_range(0, 9);
        if ($urandom_range(0, 59) == 0)
          snd_calm = !snd_calm;
      end else if (!drv_valid && snd_gap != 0) begin
        snd_gap--;
      end
      if (!busy && snd_gap == 0 && pending.size() != 0 &&
          !(pending[0].hold_back && want_q.size() != 0)) begin
        nxt = pending.pop_front();
        drv_valid <= 1'b1;
        drv_ch    <= nxt.ch;
        drv_last  <= nxt.is_last;
      end else if (!busy) begin
        drv_valid <= 1'b0;
      end
    end
  end

  // Hold off the result side once for a long stretch
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && taken_cnt >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor: check each transaction against the oldest expectation
  always @(posedge clk) begin
    result_t got_r, exp_r;
    if (rst) begin
      rcv_ready <= 1'b0;
      rcv_gap   = 0;
    end else begin
      if (result_ch.valid && rcv_ready) begin
        got_r.kind        = result_ch.kind;
        got_r.type_char   = result_ch.type_char;
        got_r.size_len    = result_ch.size_len;
        got_r.precision   = result_ch.precision;
        got_r.scale       = result_ch.scale;
        got_r.error_code  = result_ch.error_code;
        got_r.last_result = result_ch.last_result;
        if (want_q.size() == 0) begin
          bad_cnt++;
          if (bad_cnt <= 10)
            $display("unexpected result: %s", show(got_r));
        end else begin
          exp_r = want_q.pop_front();
          if (got_r !== exp_r) begin
            bad_cnt++;
            if (bad_cnt <= 10)
              $display("mismatch: expected %s\n          actual   %s",
                       show(exp_r), show(got_r));
          end
        end
        rcv_gap = rcv_calm ? 0 : $urandom_range(0, 9);
        if ($urandom_range(0, 59) == 0)
          rcv_calm = !rcv_calm;
      end else if (rcv_gap != 0) begin
        rcv_gap--;
      end
      rcv_ready <= (rcv_gap == 0) && (hold_left == 0);
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL column_spec_parser");
      $finish;
    end
  end

endmodule
